>>> design/dirc_pkg.sv
// Shared types and constants for the decimal integer range check.
`timescale 1ns / 1ps

package dirc_pkg;

	localparam int unsigned CountW = 5;
	localparam int unsigned MagW = 64;

	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	localparam logic [CountW-1:0] COUNT_SAT = 5'd20;
	localparam logic [CountW-1:0] DIGIT_CAP = 5'd19;

	localparam logic [MagW-1:0] MAX_MAGNITUDE_RST = 64'd2147483648;
	localparam logic [CountW-1:0] MAX_DIGITS_RST = 5'd10;

	localparam logic CFG_MAX_MAGNITUDE = 1'b0;
	localparam logic CFG_MAX_DIGITS = 1'b1;

	typedef enum logic [2:0] {
		REASON_OK = 3'd0,
		REASON_NO_DIGITS = 3'd1,
		REASON_TOO_MANY = 3'd2,
		REASON_NON_DIGIT = 3'd3,
		REASON_TOO_LARGE = 3'd4
	} reason_t;

	typedef struct packed {
		logic [CountW-1:0] digit_count;
		logic [MagW-1:0] magnitude_acc;
		logic is_negative;
		logic bad_char_seen;
	} str_t;

endpackage

>>> design/dirc_verdict.sv
// Verdict logic: classifies one finished string against the configured bounds.
`timescale 1ns / 1ps

module dirc_verdict (
	input dirc_pkg::str_t str,
	input logic [63:0] max_magnitude,
	input logic [4:0] max_digits,
	output dirc_pkg::reason_t reason
);
	import dirc_pkg::*;

	logic [CountW-1:0] limit;

	assign limit = (max_digits > DIGIT_CAP) ? DIGIT_CAP : max_digits;

	always_comb begin
		if (str.digit_count == '0) begin
			reason = REASON_NO_DIGITS;
		end else if (str.digit_count > limit) begin
			reason = REASON_TOO_MANY;
		end else if (str.bad_char_seen) begin
			reason = REASON_NON_DIGIT;
		end else if (str.digit_count < limit) begin
			reason = REASON_OK;
		end else if (str.magnitude_acc < max_magnitude) begin
			reason = REASON_OK;
		end else if (str.magnitude_acc == max_magnitude && str.is_negative) begin
			reason = REASON_OK;
		end else begin
			reason = REASON_TOO_LARGE;
		end
	end

endmodule

>>> design/decimal_integer_range_check.sv
// Top level of the decimal integer range check.
`timescale 1ns / 1ps

// A string enters one character per transfer on the slave stream: tdata holds
// the character, tlast marks its final character, and tuser set means the
// transfer carries no character and only ends the string. One verdict leaves
// on the master stream for each ended string: accepted in bit 0 and the
// reason code in bits 3 to 1. Intermediate characters produce no transfer.
// A character is taken every cycle unless an ending transfer waits for room.
// The ending transfer passes an update stage, which finishes the running digit
// count and magnitude, then a compare stage, which checks against the bounds
// and fills the output register. When the receiver stalls, the verdict holds
// in the output register while following characters keep flowing into the
// accumulator; a second ending transfer waits in the compare stage behind it,
// and a third one holds off the slave stream until the output register frees.
// Reset empties all stages, clears the string state and loads the default
// bounds of 2147483648 and ten digits. The user must write the bounds through
// the configuration port only while idle; the block does not enforce this.
module decimal_integer_range_check (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [7:0] s_axis_tdata, // [7:0] char_code
	input logic s_axis_tlast,
	input logic [0:0] s_axis_tuser, // [0] end_only
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [7:0] m_axis_tdata, // [0] accepted, [3:1] reason, [7:4] zero
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [63:0] cfg_wdata
);
	import dirc_pkg::*;

	logic [MagW-1:0] max_magnitude_q;
	logic [CountW-1:0] max_digits_q;

	logic valid_s1;
	logic [7:0] char_s1;
	logic end_only_s1;
	logic last_s1;

	logic [CountW-1:0] digit_count_q;
	logic [MagW-1:0] magnitude_acc_q;
	logic is_negative_q;
	logic seen_first_q;
	logic bad_char_seen_q;

	logic valid_s2;
	str_t str_s2;

	logic out_valid_q;
	reason_t reason_q;

	logic ready_out;
	logic ready_s2;
	logic ends_s1;
	logic adv_s1;

	logic take;
	logic is_minus_first;
	logic is_digit;
	logic [3:0] digit_val;
	logic [CountW-1:0] count_nx;
	logic [MagW-1:0] acc_nx;
	logic neg_nx;
	logic bad_nx;
	logic [7:0] char_off;
	reason_t reason_c;

	assign ready_out = !out_valid_q || m_axis_tready;
	assign ready_s2 = !valid_s2 || ready_out;
	assign ends_s1 = end_only_s1 || last_s1;
	assign adv_s1 = valid_s1 && (!ends_s1 || ready_s2);
	assign s_axis_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_magnitude_q <= MAX_MAGNITUDE_RST;
			max_digits_q <= MAX_DIGITS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_MAGNITUDE: max_magnitude_q <= cfg_wdata;
				CFG_MAX_DIGITS: max_digits_q <= cfg_wdata[CountW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata;
			end_only_s1 <= s_axis_tuser[0];
			last_s1 <= s_axis_tlast;
		end
	end

	assign take = !end_only_s1;
	assign is_minus_first = !seen_first_q && (char_s1 == CHAR_MINUS);
	assign is_digit = (char_s1 >= CHAR_ZERO) && (char_s1 <= CHAR_NINE);
	assign char_off = char_s1 - CHAR_ZERO;
	assign digit_val = char_off[3:0];

	always_comb begin
		count_nx = digit_count_q;
		acc_nx = magnitude_acc_q;
		neg_nx = is_negative_q;
		bad_nx = bad_char_seen_q;
		if (take) begin
			if (is_minus_first) begin
				neg_nx = 1'b1;
			end else begin
				if (is_digit) begin
					if (digit_count_q < DIGIT_CAP) begin
						acc_nx = (magnitude_acc_q << 3) + (magnitude_acc_q << 1)
							+ {{(MagW-4){1'b0}}, digit_val};
					end
				end else begin
					bad_nx = 1'b1;
				end
				if (digit_count_q < COUNT_SAT) begin
					count_nx = digit_count_q + 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_count_q <= '0;
			magnitude_acc_q <= '0;
			is_negative_q <= 1'b0;
			seen_first_q <= 1'b0;
			bad_char_seen_q <= 1'b0;
		end else if (adv_s1) begin
			if (ends_s1) begin
				digit_count_q <= '0;
				magnitude_acc_q <= '0;
				is_negative_q <= 1'b0;
				seen_first_q <= 1'b0;
				bad_char_seen_q <= 1'b0;
			end else begin
				digit_count_q <= count_nx;
				magnitude_acc_q <= acc_nx;
				is_negative_q <= neg_nx;
				seen_first_q <= seen_first_q || take;
				bad_char_seen_q <= bad_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= adv_s1 && ends_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && adv_s1 && ends_s1) begin
			str_s2.digit_count <= count_nx;
			str_s2.magnitude_acc <= acc_nx;
			str_s2.is_negative <= neg_nx;
			str_s2.bad_char_seen <= bad_nx;
		end
	end

	dirc_verdict u_verdict (
		.str(str_s2),
		.max_magnitude(max_magnitude_q),
		.max_digits(max_digits_q),
		.reason(reason_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ready_out) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_out && valid_s2) begin
			reason_q <= reason_c;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {4'b0000, reason_q, (reason_q == REASON_OK)};

endmodule

>>> test/testbench.sv
// Self-checking testbench for the decimal integer range check.
`timescale 1ns / 1ps

module testbench;
	import dirc_pkg::*;

	localparam int IDLE_PCT = 37;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 6;
	localparam int PHASE_ITEMS = 145;
	localparam int NUM_BOUNDS = 7;
	localparam logic [7:0] CHAR_PLUS = 8'h2B;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	class verdict_board;
		logic [63:0] max_mag;
		logic [4:0] max_dig;
		logic [4:0] count;
		logic [63:0] acc;
		bit neg;
		bit seen;
		bit bad;
		reason_t verdicts_due[$];
		int unsigned errors;

		function new();
			max_mag = MAX_MAGNITUDE_RST;
			max_dig = MAX_DIGITS_RST;
			errors = 0;
			clear();
		endfunction

		function void clear();
			count = '0;
			acc = '0;
			neg = 1'b0;
			seen = 1'b0;
			bad = 1'b0;
		endfunction

		function void set_register(logic idx, logic [63:0] val);
			if (idx == CFG_MAX_MAGNITUDE) begin
				max_mag = val;
			end else begin
				max_dig = val[4:0];
			end
		endfunction

		function reason_t judge();
			logic [4:0] lim;
			lim = (max_dig > DIGIT_CAP) ? DIGIT_CAP : max_dig;
			if (count == 0) return REASON_NO_DIGITS;
			if (count > lim) return REASON_TOO_MANY;
			if (bad) return REASON_NON_DIGIT;
			if (count < lim) return REASON_OK;
			if (acc < max_mag) return REASON_OK;
			if (acc == max_mag && neg) return REASON_OK;
			return REASON_TOO_LARGE;
		endfunction

		function void take_transfer(logic [7:0] c, logic eo, logic lst);
			if (!eo) begin
				if (!seen && c == CHAR_MINUS) begin
					neg = 1'b1;
					seen = 1'b1;
				end else begin
					seen = 1'b1;
					if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
						if (count < DIGIT_CAP) acc = acc * 64'd10 + 64'(c - CHAR_ZERO);
					end else begin
						bad = 1'b1;
					end
					if (count < COUNT_SAT) count = count + 5'd1;
				end
			end
			if (eo || lst) begin
				verdicts_due.push_back(judge());
				clear();
			end
		endfunction

		function void check_verdict(logic [7:0] data);
			reason_t want;
			if (verdicts_due.size() == 0) begin
				errors++;
				$error("verdict transfer with none expected: tdata %h", data);
				return;
			end
			want = verdicts_due.pop_front();
			if (data[0] !== (want == REASON_OK)) begin
				errors++;
				$error("accepted: expected %0d, got %0d", want == REASON_OK, data[0]);
			end
			if (data[3:1] !== want) begin
				errors++;
				$error("reason: expected %0d, got %0d", want, data[3:1]);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic [7:0] s_axis_tdata = '0;
	logic s_axis_tlast = 1'b0;
	logic [0:0] s_axis_tuser = '0;
	logic m_axis_tready = 1'b0;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = '0;
	logic [63:0] cfg_wdata = '0;
	wire s_axis_tready;
	wire m_axis_tvalid;
	wire [7:0] m_axis_tdata;

	bit calm = 1'b0;
	int unsigned items_sent = 0;
	int unsigned quiet_cycles = 0;
	verdict_board board = new();

	decimal_integer_range_check u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				board.take_transfer(s_axis_tdata, s_axis_tuser[0], s_axis_tlast);
			end
			if (m_axis_tvalid && m_axis_tready) board.check_verdict(m_axis_tdata);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("decimal_integer_range_check: mismatch");
				$finish;
			end
		end
	end

	task automatic send_item(input logic [7:0] c, input logic eo, input logic lst);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		s_axis_tuser <= eo;
		s_axis_tlast <= lst;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		items_sent++;
	endtask

	// A string ends either with tlast on its final character or with a separate
	// end-only transfer whose tlast is random.
	task automatic send_string(input logic [7:0] body[$]);
		int ending;
		ending = $urandom_range(3);
		if (body.size() == 0) ending = 2 + $urandom_range(1);
		foreach (body[i]) send_item(body[i], 1'b0, ending < 2 && i == body.size() - 1);
		if (ending >= 2) send_item(8'($urandom), 1'b1, ending == 3);
	endtask

	// Mostly well-formed numbers sized around the digit limit, some with one
	// character spoiled, and some short runs of arbitrary bytes.
	task automatic random_string(output logic [7:0] s[$]);
		int kind;
		int n;
		int lim;
		int pos;
		logic [63:0] v;
		logic [7:0] digs[$];
		s = {};
		digs = {};
		lim = (board.max_dig > DIGIT_CAP) ? DIGIT_CAP : board.max_dig;
		kind = $urandom_range(99);
		if (kind >= 85) begin
			n = $urandom_range(6);
			repeat (n) begin
				case ($urandom_range(3))
					0: s.push_back(CHAR_MINUS);
					1: s.push_back(CHAR_ZERO + 8'($urandom_range(9)));
					default: s.push_back(8'($urandom));
				endcase
			end
			return;
		end
		case ($urandom_range(4))
			0, 1: n = lim;
			2: n = lim - 1;
			3: n = lim + 1;
			default: n = $urandom_range(1, (lim > 0) ? lim : 1);
		endcase
		if (n < 1) n = 1;
		if (n == lim && $urandom_range(3) != 0) begin
			v = board.max_mag + 64'($urandom_range(4)) - 64'd2;
		end else begin
			v = {$urandom, $urandom};
		end
		repeat (n) begin
			digs.push_front(CHAR_ZERO + 8'(v % 64'd10));
			v = v / 64'd10;
		end
		if ($urandom_range(1)) s.push_back(CHAR_MINUS);
		s = {s, digs};
		if (kind >= 70) begin
			pos = $urandom_range(s.size() - 1);
			case ($urandom_range(3))
				0: s[pos] = CHAR_PLUS;
				1: s[pos] = CHAR_SPACE;
				2: s[pos] = CHAR_MINUS;
				default: s[pos] = 8'($urandom);
			endcase
		end
	endtask

	task automatic run_random(input int budget);
		int unsigned start;
		logic [7:0] s[$];
		start = items_sent;
		while (items_sent - start < budget) begin
			random_string(s);
			send_string(s);
		end
	endtask

	// Stops the sender and lets every verdict and any character still in the
	// pipeline drain before the bounds change.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (board.verdicts_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_bounds(input logic [63:0] mag, input logic [4:0] dig);
		cfg_we <= 1'b1;
		cfg_index <= CFG_MAX_MAGNITUDE;
		cfg_wdata <= mag;
		@(posedge clk);
		cfg_index <= CFG_MAX_DIGITS;
		cfg_wdata <= 64'(dig);
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_register(CFG_MAX_MAGNITUDE, mag);
		board.set_register(CFG_MAX_DIGITS, 64'(dig));
	endtask

	initial begin
		string bound;
		logic [63:0] bound_mags[NUM_BOUNDS];
		logic [4:0] bound_digits[NUM_BOUNDS];
		logic [63:0] mag;
		int dig;
		bound = "-2147483648";
		bound_mags = '{64'd9999999999999999999, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF,
			64'd9223372036854775808, 64'd0, 64'd255, 64'd100};
		bound_digits = '{5'd19, 5'd1, 5'd31, 5'd19, 5'd0, 5'd3, 5'd20};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(8'($urandom), 1'b1, 1'b0);
		send_item(CHAR_MINUS, 1'b0, 1'b1);
		send_item(CHAR_PLUS, 1'b0, 1'b0);
		send_item(CHAR_ZERO + 8'd5, 1'b0, 1'b1);
		send_item(CHAR_ZERO + 8'd5, 1'b0, 1'b0);
		send_item(CHAR_MINUS, 1'b0, 1'b1);
		send_item(CHAR_ZERO, 1'b0, 1'b1);
		send_item(CHAR_NINE, 1'b0, 1'b0);
		send_item(8'hFF, 1'b1, 1'b1);
		send_item(8'hFF, 1'b0, 1'b1);
		send_item(8'h00, 1'b0, 1'b1);
		foreach (bound[i]) send_item(bound[i], 1'b0, i == bound.len() - 1);
		run_random(PHASE_ITEMS);

		for (int i = 0; i < NUM_BOUNDS; i++) begin
			settle();
			write_bounds(bound_mags[i], bound_digits[i]);
			calm <= (i == 2);
			run_random(PHASE_ITEMS);
		end

		repeat (2) begin
			settle();
			dig = $urandom_range(1, 19);
			mag = 64'($urandom_range(1, 9));
			repeat (dig - 1) mag = mag * 64'd10 + 64'($urandom_range(9));
			write_bounds(mag, 5'(dig));
			calm <= 1'b0;
			run_random(PHASE_ITEMS);
		end

		settle();
		if (board.errors == 0 && board.verdicts_due.size() == 0) begin
			$display("decimal_integer_range_check: match");
		end else begin
			$display("decimal_integer_range_check: mismatch");
		end
		$finish;
	end

endmodule

>>> sim.f
design/dirc_pkg.sv
design/dirc_verdict.sv
design/decimal_integer_range_check.sv
test/testbench.sv
